@@ src/ensemble_prediction_combiner_assert.svh @@
// Assertion macros used by the checker file of the combiner.
// Needs nothing else; the checker includes this header by its bare name.
`ifndef ENSEMBLE_PREDICTION_COMBINER_ASSERT_SVH
`define ENSEMBLE_PREDICTION_COMBINER_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define EPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define EPC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/epc_pkg.sv @@
// Constants, register and mode codes, and divider pipe payload of the combiner.
// No dependencies.
`default_nettype none
package epc_pkg;
  localparam int LANES       = 4;
  localparam int PRED_W      = 16;
  localparam int WEIGHT_W    = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int COUNT_W     = 3;
  localparam int Q_SHIFT     = 12;
  localparam int Q_HALF      = 2048;
  localparam int VOTE_SCALE  = 100;
  localparam int DYN_MIN_TOT = 656;
  localparam int DIV_STEPS   = 17;
  localparam int REM_W       = 37;
  localparam int DEN_W       = 20;
  localparam int RS_W        = 21;

  localparam logic [1:0] MODE_AVG  = 2'd0;
  localparam logic [1:0] MODE_WGT  = 2'd1;
  localparam logic [1:0] MODE_VOTE = 2'd2;
  localparam logic [1:0] MODE_DYN  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_W1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_W3    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 3'd6;

  localparam logic [1:0]          RST_MODE   = MODE_WGT;
  localparam logic [COUNT_W-1:0]  RST_COUNT  = 3'd4;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT = 16'd16384;
  localparam logic [WEIGHT_W-1:0] RST_FLOOR  = 16'd52429;

  typedef struct packed {
    logic                    shift_path;
    logic signed [RS_W-1:0]  rs;
    logic                    zd;
    logic                    fb;
    logic                    neg;
    logic [REM_W-1:0]        rem;
    logic [DEN_W-1:0]        den;
    logic [DIV_STEPS-1:0]    quo;
  } pipe_t;
endpackage
`default_nettype wire

@@ src/epc_if.sv @@
// Valid/ready channel interfaces for samples, results and register writes.
// Widths come from epc_pkg.
`default_nettype none
interface epc_sample_if;
  logic valid;
  logic ready;
  logic signed [epc_pkg::PRED_W-1:0] pred_0, pred_1, pred_2, pred_3;
  logic [epc_pkg::WEIGHT_W-1:0]      conf_0, conf_1, conf_2, conf_3;
  modport source(output valid, pred_0, pred_1, pred_2, pred_3,
                 conf_0, conf_1, conf_2, conf_3, input ready);
  modport sink(input valid, pred_0, pred_1, pred_2, pred_3,
               conf_0, conf_1, conf_2, conf_3, output ready);
endinterface

interface epc_result_if;
  logic valid;
  logic ready;
  logic signed [epc_pkg::PRED_W-1:0] combined_value;
  logic saturated;
  logic fallback_used;
  logic zero_divisor;
  modport source(output valid, combined_value, saturated, fallback_used,
                 zero_divisor, input ready);
  modport sink(input valid, combined_value, saturated, fallback_used,
               zero_divisor, output ready);
endinterface

interface epc_cfg_if;
  logic valid;
  logic ready;
  logic [epc_pkg::CFG_IDX_W-1:0] index;
  logic [epc_pkg::WEIGHT_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/ensemble_prediction_combiner.sv @@
// Ensemble prediction combiner: one result beat per sample beat; a new sample is
// accepted every cycle while no backpressure holds the pipe. Three lane stages
// (products, weighted products with sums, final sums) feed a setup stage and a
// 17-stage restoring divider, one quotient bit per stage, then a clip stage that
// is the output register. The divider depth sets the latency. Every stage has its
// own valid bit and loads whenever it is empty or its successor moves, so bubbles
// close up under backpressure. Register writes are taken every cycle and should
// only happen while the pipe is empty. Depends on epc_pkg and epc_if.sv.
`default_nettype none
module ensemble_prediction_combiner (
  input  logic      clk,
  input  logic      rst,
  epc_sample_if.sink  sample,
  epc_result_if.source result,
  epc_cfg_if.sink     cfg
);
  localparam int L  = epc_pkg::LANES;
  localparam int NS = epc_pkg::DIV_STEPS;

  // ---------------- configuration registers ----------------
  logic [1:0]                     mode;
  logic [epc_pkg::COUNT_W-1:0]    count;
  logic [epc_pkg::WEIGHT_W-1:0]   weight [L];
  logic [epc_pkg::WEIGHT_W-1:0]   conf_floor;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= epc_pkg::RST_MODE;
      count      <= epc_pkg::RST_COUNT;
      conf_floor <= epc_pkg::RST_FLOOR;
      for (int i = 0; i < L; i++) weight[i] <= epc_pkg::RST_WEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        epc_pkg::REG_MODE:  mode       <= cfg.data[1:0];
        epc_pkg::REG_COUNT: count      <= cfg.data[epc_pkg::COUNT_W-1:0];
        epc_pkg::REG_W0:    weight[0]  <= cfg.data;
        epc_pkg::REG_W1:    weight[1]  <= cfg.data;
        epc_pkg::REG_W2:    weight[2]  <= cfg.data;
        epc_pkg::REG_W3:    weight[3]  <= cfg.data;
        epc_pkg::REG_FLOOR: conf_floor <= cfg.data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // model count clamped to 1..LANES
  logic [epc_pkg::COUNT_W-1:0] n_eff;
  always_comb begin
    if (count == '0) n_eff = epc_pkg::COUNT_W'(1);
    else if (count > epc_pkg::COUNT_W'(L)) n_eff = epc_pkg::COUNT_W'(L);
    else n_eff = count;
  end

  // ---------------- handshake chain ----------------
  logic a_vld, b_vld, c_vld, e_vld;
  logic p_vld [NS+1];
  logic adv_a, adv_b, adv_c, adv_e;
  logic adv_p [NS+1];

  always_comb begin
    adv_e = !e_vld || result.ready;
    adv_p[NS] = !p_vld[NS] || adv_e;
    for (int k = NS - 1; k >= 0; k--) adv_p[k] = !p_vld[k] || adv_p[k+1];
    adv_c = !c_vld || adv_p[0];
    adv_b = !b_vld || adv_c;
    adv_a = !a_vld || adv_b;
  end
  assign sample.ready = adv_a;

  // ---------------- stage A: lane products ----------------
  logic signed [epc_pkg::PRED_W-1:0] p_in [L];
  logic [epc_pkg::WEIGHT_W-1:0]      c_in [L];
  assign p_in[0] = sample.pred_0;
  assign p_in[1] = sample.pred_1;
  assign p_in[2] = sample.pred_2;
  assign p_in[3] = sample.pred_3;
  assign c_in[0] = sample.conf_0;
  assign c_in[1] = sample.conf_1;
  assign c_in[2] = sample.conf_2;
  assign c_in[3] = sample.conf_3;

  logic signed [epc_pkg::PRED_W-1:0] a_p_next [L], a_p [L];
  logic signed [32:0] a_wp_next [L], a_wp [L];
  logic [15:0]        a_dw_next [L], a_dw [L];
  logic [6:0]         a_v_next [L], a_v [L];
  logic [6:0]         a_vp_next [L], a_vp [L];
  logic [31:0]        wc [L];
  logic [22:0]        wv [L];
  logic               lane_en [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      lane_en[i]   = n_eff > epc_pkg::COUNT_W'(i);
      wc[i]        = 32'(weight[i]) * 32'(c_in[i]);
      wv[i]        = 23'(weight[i]) * 23'(epc_pkg::VOTE_SCALE);
      a_p_next[i]  = lane_en[i] ? p_in[i] : '0;
      // signed product; both arms signed so the prediction keeps its sign
      a_wp_next[i] = lane_en[i] ? 33'($signed({1'b0, weight[i]})) * 33'(p_in[i])
                                : 33'sd0;
      // dynamic weight counts only at or above the confidence floor
      a_dw_next[i] = (lane_en[i] && c_in[i] >= conf_floor) ? wc[i][31:16] : '0;
      a_v_next[i]  = lane_en[i] ? wv[i][22:16] : '0;
      a_vp_next[i] = (p_in[i] > 16'(epc_pkg::Q_HALF)) ? a_v_next[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (adv_a) a_vld <= sample.valid;
  end
  always_ff @(posedge clk) begin
    if (adv_a && sample.valid) begin
      a_p <= a_p_next; a_wp <= a_wp_next; a_dw <= a_dw_next;
      a_v <= a_v_next; a_vp <= a_vp_next;
    end
  end

  // ---------------- stage B: dynamic products, small sums ----------------
  logic signed [32:0] b_dwp_next [L], b_dwp [L];
  logic signed [34:0] b_sw_next, b_sw;
  logic [17:0]        b_tot_next, b_tot;
  logic [8:0]         b_pos_next, b_pos, b_vt_next, b_vt;
  logic signed [17:0] b_sp_next, b_sp;

  always_comb begin
    b_sw_next = '0; b_tot_next = '0; b_pos_next = '0; b_vt_next = '0; b_sp_next = '0;
    for (int i = 0; i < L; i++) begin
      b_dwp_next[i] = 33'($signed({1'b0, a_dw[i]})) * 33'(a_p[i]);
      b_sw_next  = b_sw_next + 35'(a_wp[i]);
      b_tot_next = b_tot_next + 18'(a_dw[i]);
      b_pos_next = b_pos_next + 9'(a_vp[i]);
      b_vt_next  = b_vt_next + 9'(a_v[i]);
      b_sp_next  = b_sp_next + 18'(a_p[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (adv_b) b_vld <= a_vld;
  end
  always_ff @(posedge clk) begin
    if (adv_b && a_vld) begin
      b_dwp <= b_dwp_next; b_sw <= b_sw_next; b_tot <= b_tot_next;
      b_pos <= b_pos_next; b_vt <= b_vt_next; b_sp <= b_sp_next;
    end
  end

  // ---------------- stage C: dynamic numerator ----------------
  logic signed [34:0] c_num_next, c_num, c_sw;
  logic [17:0]        c_tot;
  logic [8:0]         c_pos, c_vt;
  logic signed [17:0] c_sp;

  always_comb begin
    c_num_next = '0;
    for (int i = 0; i < L; i++) c_num_next = c_num_next + 35'(b_dwp[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (adv_c) c_vld <= b_vld;
  end
  always_ff @(posedge clk) begin
    if (adv_c && b_vld) begin
      c_num <= c_num_next; c_sw <= b_sw; c_tot <= b_tot;
      c_pos <= b_pos; c_vt <= b_vt; c_sp <= b_sp;
    end
  end

  // ---------------- setup: numerator/denominator, shift path ----------------
  // round(N/D) = floor((2N + D) / 2D); sign is split off for the divider.
  epc_pkg::pipe_t     pv [NS+1];
  epc_pkg::pipe_t     setup;
  logic signed [35:0] sh_val, sh_rnd;
  logic signed [34:0] num_sel;
  logic [18:0]        den_sel;
  logic signed [36:0] a_full;

  always_comb begin
    setup.fb = (mode == epc_pkg::MODE_DYN) && (c_tot < 18'(epc_pkg::DYN_MIN_TOT));
    setup.zd = (mode == epc_pkg::MODE_VOTE) && (c_vt == '0);
    setup.shift_path = (mode == epc_pkg::MODE_WGT) || setup.fb;
    sh_val = (mode == epc_pkg::MODE_WGT) ? 36'(c_sw) : 36'(c_num) + 36'(c_sw);
    sh_rnd = (sh_val + 36'sd32768) >>> 16;
    setup.rs = sh_rnd[epc_pkg::RS_W-1:0];
    unique case (mode)
      epc_pkg::MODE_AVG: begin
        num_sel = 35'(c_sp);
        den_sel = 19'(n_eff);
      end
      epc_pkg::MODE_VOTE: begin
        num_sel = $signed({14'b0, c_pos, 12'b0});
        den_sel = setup.zd ? 19'd1 : 19'(c_vt);
      end
      epc_pkg::MODE_DYN: begin
        num_sel = c_num;
        den_sel = {1'b0, c_tot};
      end
      default: begin
        num_sel = '0;
        den_sel = 19'd1;
      end
    endcase
    a_full    = (37'(num_sel) <<< 1) + $signed({18'b0, den_sel});
    setup.neg = a_full[36];
    setup.rem = setup.neg ? 37'(-a_full) : 37'(a_full);
    setup.den = {den_sel, 1'b0};
    setup.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) p_vld[0] <= 1'b0;
    else if (adv_p[0]) p_vld[0] <= c_vld;
  end
  always_ff @(posedge clk) begin
    if (adv_p[0] && c_vld) pv[0] <= setup;
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar k = 1; k <= NS; k++) begin : g_div
    localparam int B = NS - k;
    epc_pkg::pipe_t          step;
    logic [epc_pkg::REM_W-1:0] trial;
    always_comb begin
      step  = pv[k-1];
      trial = epc_pkg::REM_W'(pv[k-1].den) << B;
      if (pv[k-1].rem >= trial) begin
        step.rem    = pv[k-1].rem - trial;
        step.quo[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) p_vld[k] <= 1'b0;
      else if (adv_p[k]) p_vld[k] <= p_vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv_p[k] && p_vld[k-1]) pv[k] <= step;
    end
  end

  // ---------------- output: floor fix, select, clip ----------------
  logic signed [18:0] q_abs, q_fl;
  logic signed [20:0] res;
  logic signed [epc_pkg::PRED_W-1:0] val_next, val;
  logic sat_next, sat, fb_r, zd_r;

  always_comb begin
    q_abs = $signed({2'b0, pv[NS].quo});
    q_fl  = pv[NS].neg ? -(q_abs + 19'(pv[NS].rem != '0)) : q_abs;
    if (pv[NS].shift_path) res = pv[NS].rs;
    else if (pv[NS].zd)    res = '0;
    else                   res = 21'(q_fl);
    sat_next = 1'b0;
    if (res > 21'sd32767) begin
      val_next = 16'sh7fff; sat_next = 1'b1;
    end else if (res < -21'sd32768) begin
      val_next = 16'sh8000; sat_next = 1'b1;
    end else begin
      val_next = res[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (adv_e) e_vld <= p_vld[NS];
  end
  always_ff @(posedge clk) begin
    if (adv_e && p_vld[NS]) begin
      val <= val_next; sat <= sat_next; fb_r <= pv[NS].fb; zd_r <= pv[NS].zd;
    end
  end

  assign result.valid          = e_vld;
  assign result.combined_value = val;
  assign result.saturated      = sat;
  assign result.fallback_used  = fb_r;
  assign result.zero_divisor   = zd_r;
endmodule
`default_nettype wire

@@ src/epc_checker.sv @@
// Port-level checks on the combiner's result channel, bound to the top level.
// Uses the macros of ensemble_prediction_combiner_assert.svh.
`default_nettype none
`include "ensemble_prediction_combiner_assert.svh"
module epc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        r_valid,
  input wire logic        r_ready,
  input wire logic [15:0] r_value,
  input wire logic        r_sat,
  input wire logic        r_zd
);
  `EPC_ASSERT(a_hold, clk, rst, r_valid && !r_ready |=> r_valid, "result beat dropped")
  `EPC_ASSERT_NR(a_rst, clk, rst |=> !r_valid, "result valid after reset")
  `EPC_ASSERT(a_zd, clk, rst, r_valid && r_zd |-> r_value == 16'h0000 && !r_sat, "zero total")
  `EPC_ASSERT(a_sat, clk, rst, r_valid && r_sat |-> r_value == 16'h7fff || r_value == 16'h8000, "clip")
endmodule

bind ensemble_prediction_combiner epc_checker u_epc_checker (
  .clk(clk), .rst(rst),
  .r_valid(result.valid), .r_ready(result.ready),
  .r_value(result.combined_value), .r_sat(result.saturated),
  .r_zd(result.zero_divisor)
);
`default_nettype wire
